// ----- hw/rtl/fqs_pkg.sv -----
// shared types, codes and widths for the fifo queue with statistics
`timescale 1ns / 1ps

package fqs_pkg;

    // payload field widths
    localparam int VALUE_W   = 32;
    localparam int TOTAL_W   = 40;
    localparam int AVERAGE_W = 32;
    localparam int OCC_W     = 9;

    // default sizing
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STAT  = 2'd2,
        OP_CLEAR = 2'd3
    } t_fqs_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_fqs_status;

    typedef struct packed {
        t_fqs_op              operation;
        logic [VALUE_W-1:0]   value;
    } t_fqs_cmd;

    typedef struct packed {
        t_fqs_status          status;
        logic [VALUE_W-1:0]   popped_value;
        logic [VALUE_W-1:0]   minimum;
        logic [VALUE_W-1:0]   maximum;
        logic [TOTAL_W-1:0]   total;
        logic [AVERAGE_W-1:0] average;
        logic [OCC_W-1:0]     occupancy;
    } t_fqs_res;

endpackage

// ----- hw/rtl/fqs_cmd_if.sv -----
// command channel: valid/ready handshake with operation and value
`timescale 1ns / 1ps

interface fqs_cmd_if;
    logic             valid;
    logic             ready;
    fqs_pkg::t_fqs_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/fqs_res_if.sv -----
// result channel: valid/ready handshake with status and statistics
`timescale 1ns / 1ps

interface fqs_res_if;
    logic             valid;
    logic             ready;
    fqs_pkg::t_fqs_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/fifo_queue_with_statistics.sv -----
// Push and clear go from accept through the finish state to the output register;
// pop first passes the pop state to take the ram read data. Statistics: the walk
// reads each held entry over the ram read port, then the divider takes one step
// per bit of the value bits + count bits dividend. Flow: one transaction at a
// time; the next is taken once the previous result is registered.
// Reset: synchronous active low, clears pointers, count, sequencer and result
// valid; the entry store keeps whatever it holds and needs no clearing pass.
`timescale 1ns / 1ps

module fifo_queue_with_statistics #(
    parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF,
    parameter int VALUE_WIDTH = fqs_pkg::VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fqs_cmd_if.sink       i_cmd,
    fqs_res_if.source     o_res
);

    // stored value width: the command field caps it at the port width
    localparam int SW    = (VALUE_WIDTH < fqs_pkg::VALUE_W) ? VALUE_WIDTH
                                                            : fqs_pkg::VALUE_W;
    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUMW  = SW + CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

    // sequencer, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_WALK = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_fqs_state;

    // ring pointer increment, wraps at any depth
    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] p);
        f_adv = (p == LAST_C) ? '0 : p + AW'(1);
    endfunction

    t_fqs_state         r_state, n_state;
    logic [AW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]      r_count, n_count;

    // statistics walk
    logic [AW-1:0]      r_walk_ptr, n_walk_ptr;
    logic [CW-1:0]      r_left, n_left;
    logic               r_first, n_first;
    logic [SW-1:0]      r_min, n_min;
    logic [SW-1:0]      r_max, n_max;
    logic [SUMW-1:0]    r_sum, n_sum;

    // result being built and the output register
    fqs_pkg::t_fqs_res  r_pend, n_pend;
    fqs_pkg::t_fqs_res  r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // ram and divider hookup
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [SW-1:0]      ram_wdata;
    logic [SW-1:0]      ram_rdata;
    logic               div_start;
    logic               div_done;
    logic [SUMW-1:0]    div_quo;
    logic               cmd_acc;

    fqs_ram #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // average = sum / count, count is never zero here
    fqs_div #(
        .DIVIDEND_W (SUMW),
        .DIVISOR_W  (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign cmd_acc       = i_cmd.valid && (r_state == S_IDLE);
    assign ram_wdata     = SW'(i_cmd.payload.value);
    // idle reads the oldest slot so pop and walk data arrive next cycle
    assign ram_raddr     = (r_state == S_IDLE) ? r_rd_ptr : r_walk_ptr;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_walk_ptr  = r_walk_ptr;
        n_left      = r_left;
        n_first     = r_first;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        ram_we      = 1'b0;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    n_pend        = '0;
                    n_pend.status = fqs_pkg::ST_OK;
                    n_state       = S_FIN;
                    unique case (i_cmd.payload.operation)
                        fqs_pkg::OP_PUSH: begin
                            if (r_count == DEPTH_C) begin
                                n_pend.status = fqs_pkg::ST_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                n_wr_ptr = f_adv(r_wr_ptr);
                                n_count  = r_count + CW'(1);
                            end
                        end
                        fqs_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_pend.status = fqs_pkg::ST_EMPTY;
                            end else begin
                                n_rd_ptr = f_adv(r_rd_ptr);
                                n_count  = r_count - CW'(1);
                                n_state  = S_POP;
                            end
                        end
                        fqs_pkg::OP_STAT: begin
                            if (r_count == '0) begin
                                n_pend.status = fqs_pkg::ST_EMPTY;
                            end else begin
                                n_walk_ptr = f_adv(r_rd_ptr);
                                n_left     = r_count;
                                n_first    = 1'b1;
                                n_sum      = '0;
                                n_state    = S_WALK;
                            end
                        end
                        fqs_pkg::OP_CLEAR: begin
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                            n_count  = '0;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_pend.popped_value = fqs_pkg::VALUE_W'(ram_rdata);
                n_state             = S_FIN;
            end
            S_WALK: begin
                // one entry per cycle through the shared add/compare
                n_sum      = r_sum + SUMW'(ram_rdata);
                n_min      = (r_first || ram_rdata < r_min) ? ram_rdata : r_min;
                n_max      = (r_first || ram_rdata > r_max) ? ram_rdata : r_max;
                n_first    = 1'b0;
                n_walk_ptr = f_adv(r_walk_ptr);
                n_left     = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_pend.minimum = fqs_pkg::VALUE_W'(r_min);
                    n_pend.maximum = fqs_pkg::VALUE_W'(r_max);
                    n_pend.total   = fqs_pkg::TOTAL_W'(r_sum);
                    n_pend.average = fqs_pkg::AVERAGE_W'(div_quo);
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                // hand off once the output register is free or draining
                if (!r_out_valid || o_res.ready) begin
                    n_out           = r_pend;
                    n_out.occupancy = fqs_pkg::OCC_W'(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_walk_ptr <= n_walk_ptr;
        r_left     <= n_left;
        r_first    <= n_first;
        r_min      <= n_min;
        r_max      <= n_max;
        r_sum      <= n_sum;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above queue depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && i_cmd.payload.operation == fqs_pkg::OP_PUSH && r_count != DEPTH_C)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("accepted push did not grow the count");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_left != '0)
        else $error("statistics walk with no entries left");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.status == fqs_pkg::ST_EMPTY)
        |-> (o_res.payload.total == '0 && o_res.payload.popped_value == '0))
        else $error("empty error result carries data");

    a_div_in_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside a statistics transaction");

endmodule

// ----- hw/rtl/fqs_ram.sv -----
// generic simple dual-port ram, one write port, registered read port
`timescale 1ns / 1ps

module fqs_ram #(
    parameter int WIDTH = fqs_pkg::VALUE_W,
    parameter int DEPTH = fqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fqs_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fqs_div #(
    parameter int DIVIDEND_W = 49,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    // shift in next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> i_divisor != '0)
        else $error("divider started with zero divisor");

endmodule

// ----- dv/tb_fifo_queue_with_statistics.sv -----
// self-checking testbench for the fifo queue with statistics
`timescale 1ns / 1ps

module tb_fifo_queue_with_statistics;

    localparam int  DEPTH        = fqs_pkg::QUEUE_DEPTH_DEF;
    localparam int  VALUE_W      = fqs_pkg::VALUE_W;
    localparam int  TOTAL_W      = fqs_pkg::TOTAL_W;
    localparam int  AVERAGE_W    = fqs_pkg::AVERAGE_W;
    localparam int  OCC_W        = fqs_pkg::OCC_W;
    localparam real CLK_PERIOD   = 12.0;
    // worst case per transaction: full statistics walk plus divide, plus the
    // longest sender gap and receiver stall; about 600 transactions at that worst
    // case still leave a wide margin under this limit
    localparam int  CYCLE_LIMIT  = 1_500_000;
    // longest single transaction is a statistics walk over a full queue
    localparam int  DRAIN_CYCLES = 400;
    localparam int  MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    fqs_cmd_if cmd_ch ();
    fqs_res_if res_ch ();

    fifo_queue_with_statistics dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // shadow copy of the queue, updated once per accepted command
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    logic [7:0]         shadow_rd;
    logic [7:0]         shadow_wr;
    int                 shadow_count;

    // results still owed by the block, oldest first
    fqs_pkg::t_fqs_res pending_results [$];

    // run control and bookkeeping
    bit idle_on;
    int hold_left;
    int cycle_count;
    int mismatches;
    int op_count [4];
    int dropped_pushes;
    int empty_errors;
    int peak_occupancy;

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // watchdog: a stuck handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // next queue state and the result the block must give for one command
    function automatic fqs_pkg::t_fqs_res predict_queue_op(fqs_pkg::t_fqs_op op,
                                                           logic [VALUE_W-1:0] val);
        fqs_pkg::t_fqs_res  res;
        logic [7:0]         slot;
        logic [TOTAL_W-1:0] sum;
        logic [VALUE_W-1:0] entry;
        int                 i;
        res        = '0;
        res.status = fqs_pkg::ST_OK;
        case (op)
            fqs_pkg::OP_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    res.status = fqs_pkg::ST_FULL;
                end else begin
                    shadow_store[shadow_wr] = val;
                    shadow_wr++;
                    shadow_count++;
                end
            end
            fqs_pkg::OP_POP: begin
                if (shadow_count == 0) begin
                    res.status = fqs_pkg::ST_EMPTY;
                end else begin
                    res.popped_value = shadow_store[shadow_rd];
                    shadow_rd++;
                    shadow_count--;
                end
            end
            fqs_pkg::OP_STAT: begin
                if (shadow_count == 0) begin
                    res.status = fqs_pkg::ST_EMPTY;
                end else begin
                    slot        = shadow_rd;
                    sum         = '0;
                    res.minimum = shadow_store[slot];
                    res.maximum = shadow_store[slot];
                    for (i = 0; i < shadow_count; i++) begin
                        entry = shadow_store[slot];
                        sum   = sum + TOTAL_W'(entry);
                        if (entry > res.maximum) res.maximum = entry;
                        if (entry < res.minimum) res.minimum = entry;
                        slot++;
                    end
                    res.total   = sum;
                    res.average = AVERAGE_W'(sum / TOTAL_W'(shadow_count));
                end
            end
            default: begin
                shadow_rd    = '0;
                shadow_wr    = '0;
                shadow_count = 0;
            end
        endcase
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    // offer one command and hold it until the block takes it; the expectation
    // is recorded at the accepting edge, then an optional idle burst follows
    task automatic send_cmd(input fqs_pkg::t_fqs_op op, input logic [VALUE_W-1:0] val);
        fqs_pkg::t_fqs_cmd cmd;
        fqs_pkg::t_fqs_res res;
        cmd.operation = op;
        cmd.value     = val;
        cmd_ch.payload <= cmd;
        cmd_ch.valid   <= 1'b1;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        res = predict_queue_op(op, val);
        pending_results.push_back(res);
        op_count[op]++;
        if (res.status == fqs_pkg::ST_FULL)  dropped_pushes++;
        if (res.status == fqs_pkg::ST_EMPTY) empty_errors++;
        if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // value mix leaning on the corners
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'($urandom_range(0, 255));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // receiver: long hold when a test asks for one, else random stall bursts when idle_on is set
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void show_result(string tag, fqs_pkg::t_fqs_res r);
        $display("  %s: status=%s popped=%h min=%h max=%h total=%h avg=%h occ=%0d",
                 tag, r.status.name(), r.popped_value, r.minimum, r.maximum,
                 r.total, r.average, r.occupancy);
    endfunction

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk) begin
        fqs_pkg::t_fqs_res got;
        fqs_pkg::t_fqs_res exp_res;
        bit                same;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got = res_ch.payload;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] result with no command outstanding", $realtime);
                    show_result("actual  ", got);
                end
            end else begin
                exp_res = pending_results.pop_front();
                same = (got.status       === exp_res.status)
                    && (got.popped_value === exp_res.popped_value)
                    && (got.minimum      === exp_res.minimum)
                    && (got.maximum      === exp_res.maximum)
                    && (got.total        === exp_res.total)
                    && (got.average      === exp_res.average)
                    && (got.occupancy    === exp_res.occupancy);
                if (!same) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] result mismatch", $realtime);
                        show_result("expected", exp_res);
                        show_result("actual  ", got);
                    end
                end
            end
        end
    end

    // pop, statistics and clear on a fresh, empty queue
    task automatic test_empty_queue();
        send_cmd(fqs_pkg::OP_POP,   32'h1234_5678);
        send_cmd(fqs_pkg::OP_STAT,  '1);
        send_cmd(fqs_pkg::OP_CLEAR, '1);
        send_cmd(fqs_pkg::OP_POP,   '0);
    endtask

    // extreme values, every operation, min and max at both ends of the contents
    task automatic test_value_extremes();
        send_cmd(fqs_pkg::OP_PUSH,  '0);
        send_cmd(fqs_pkg::OP_PUSH,  '1);
        send_cmd(fqs_pkg::OP_PUSH,  32'h0000_0001);
        send_cmd(fqs_pkg::OP_PUSH,  32'h8000_0000);
        send_cmd(fqs_pkg::OP_PUSH,  32'h7FFF_FFFF);
        send_cmd(fqs_pkg::OP_STAT,  32'hA5A5_A5A5);
        send_cmd(fqs_pkg::OP_POP,   32'h5A5A_5A5A);
        send_cmd(fqs_pkg::OP_STAT,  '0);
        send_cmd(fqs_pkg::OP_POP,   '0);
        send_cmd(fqs_pkg::OP_POP,   '0);
        send_cmd(fqs_pkg::OP_POP,   '0);
        send_cmd(fqs_pkg::OP_STAT,  '0);
        send_cmd(fqs_pkg::OP_CLEAR, '0);
        send_cmd(fqs_pkg::OP_STAT,  '0);
    endtask

    // fill with all-ones for the largest total, push into a full queue,
    // then wrap both pointers past the end of the store
    task automatic test_full_queue();
        int i;
        for (i = 0; i < DEPTH; i++) send_cmd(fqs_pkg::OP_PUSH, '1);
        send_cmd(fqs_pkg::OP_PUSH, 32'hDEAD_BEEF);
        send_cmd(fqs_pkg::OP_STAT, '0);
        send_cmd(fqs_pkg::OP_PUSH, '0);
        for (i = 0; i < 5; i++) send_cmd(fqs_pkg::OP_POP, '0);
        for (i = 0; i < 5; i++) send_cmd(fqs_pkg::OP_PUSH, VALUE_W'(i));
        send_cmd(fqs_pkg::OP_PUSH, '1);
        send_cmd(fqs_pkg::OP_STAT, '0);
        for (i = 0; i < DEPTH - 3; i++) send_cmd(fqs_pkg::OP_POP, '0);
        send_cmd(fqs_pkg::OP_STAT, '0);
        send_cmd(fqs_pkg::OP_CLEAR, '0);
    endtask

    // receiver holds off while commands keep coming, so the block backs up
    task automatic test_result_backpressure();
        int i;
        hold_left = 300;
        for (i = 0; i < 10; i++) send_cmd(fqs_pkg::OP_PUSH, pick_value());
        send_cmd(fqs_pkg::OP_STAT,  '0);
        send_cmd(fqs_pkg::OP_POP,   '0);
        send_cmd(fqs_pkg::OP_CLEAR, '0);
    endtask

    // random mix with the given weights per operation
    task automatic test_random_traffic(int n, int w_push, int w_pop, int w_stat, int w_clear);
        int               i;
        int               r;
        fqs_pkg::t_fqs_op op;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, w_push + w_pop + w_stat + w_clear - 1);
            if (r < w_push)                       op = fqs_pkg::OP_PUSH;
            else if (r < w_push + w_pop)          op = fqs_pkg::OP_POP;
            else if (r < w_push + w_pop + w_stat) op = fqs_pkg::OP_STAT;
            else                                  op = fqs_pkg::OP_CLEAR;
            // pushes draw from the corner-heavy mix
            send_cmd(op, (op == fqs_pkg::OP_PUSH) ? pick_value() : VALUE_W'($urandom));
        end
    endtask

    // main sequence
    initial begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        shadow_rd       = '0;
        shadow_wr       = '0;
        shadow_count    = 0;
        hold_left       = 0;
        mismatches      = 0;
        dropped_pushes  = 0;
        empty_errors    = 0;
        peak_occupancy  = 0;
        op_count        = '{default: 0};
        idle_on         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        idle_on = 1'b1;
        test_value_extremes();
        test_full_queue();
        test_result_backpressure();
        test_random_traffic(12, 60, 25, 12, 3);
        test_random_traffic(8, 30, 55, 12, 3);
        // last stretch runs back to back on both sides
        idle_on = 1'b0;
        test_random_traffic(16, 45, 40, 12, 3);
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_results.size();

        $display("ran %0d pushes (%0d dropped on a full queue), %0d pops, %0d statistics, %0d clears",
                 op_count[fqs_pkg::OP_PUSH], dropped_pushes, op_count[fqs_pkg::OP_POP],
                 op_count[fqs_pkg::OP_STAT], op_count[fqs_pkg::OP_CLEAR]);
        $display("%0d empty-queue errors, peak occupancy %0d, %0d mismatches, %0d cycles",
                 empty_errors, peak_occupancy, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_cmd_if.sv
hw/rtl/fqs_res_if.sv
hw/rtl/fqs_ram.sv
hw/rtl/fqs_div.sv
hw/rtl/fifo_queue_with_statistics.sv
dv/tb_fifo_queue_with_statistics.sv
